// ===== rtl/assert_macros.svh =====
// Assertion macros for the cross-track offset block.
// No dependencies; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/plcto_pkg.sv =====
// Package for the parallel-line cross-track offset block.
// Register indexes, field widths and the output saturation helper.
package plcto_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FieldW = 32;
  localparam int unsigned SpacingW = 17;
  localparam int unsigned OffsetW = 18;
  localparam int unsigned LineW = 10;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegAx = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAy = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBx = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBy = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpacing = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOffset = 3'd5;

  // clamp to a cw-bit signed range, return the low field bits
  function automatic logic [FieldW-1:0] sat_field(input logic signed [63:0] v,
                                                  input int unsigned cw);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic signed [63:0] r;
    hi = (64'sd1 <<< (cw - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    r = v;
    if (v > hi) r = hi;
    if (v < lo) r = lo;
    return r[FieldW-1:0];
  endfunction

endpackage

// ===== rtl/parallel_line_cross_track_offset.sv =====
// Top level of the parallel-line cross-track offset block.
// Uses plcto_pkg and assert_macros.svh.
//
// After any register write the block derives the unit direction of AB with an
// iterative sequencer (normalize, square root, then two dividers in parallel)
// and holds in_ready_o low after the last write until the new direction is
// loaded. Once done it takes one request per cycle while the output register
// is not held; each request flows through five register stages and then the
// output register.
// A = B sets degenerate_o with zero results.
module parallel_line_cross_track_offset #(
  parameter int unsigned COORD_WIDTH = plcto_pkg::CoordWidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [plcto_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [plcto_pkg::FieldW-1:0]           cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [plcto_pkg::FieldW-1:0]    pos_x_i,
  input  logic signed [plcto_pkg::FieldW-1:0]    pos_y_i,
  input  logic signed [plcto_pkg::LineW-1:0]     line_number_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [plcto_pkg::FieldW-1:0]    signed_distance_o,
  output logic signed [plcto_pkg::FieldW-1:0]    foot_x_o,
  output logic signed [plcto_pkg::FieldW-1:0]    foot_y_o,
  output logic                                   degenerate_o
);
  import plcto_pkg::*;

  typedef enum logic [2:0] {StIdle, StLoad, StNorm, StSqrt, StDivLoad, StDiv} state_e;

  // configuration registers
  logic signed [31:0] ax_q, ay_q, bx_q, by_q;
  logic [SpacingW-1:0] sp_q;
  logic signed [OffsetW-1:0] off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0; sp_q <= '0; off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegAx:      ax_q <= cfg_wdata_i;
        RegAy:      ay_q <= cfg_wdata_i;
        RegBx:      bx_q <= cfg_wdata_i;
        RegBy:      by_q <= cfg_wdata_i;
        RegSpacing: sp_q <= cfg_wdata_i[SpacingW-1:0];
        RegOffset:  off_q <= cfg_wdata_i[OffsetW-1:0];
        default: ;
      endcase
    end
  end

  // unit direction sequencer
  state_e state_q;
  logic signed [32:0] dx_q, dy_q;
  logic [32:0] ex_q, ey_q;
  logic [61:0] x_q, res_q;
  logic [60:0] bit_q;
  logic [59:0] nx_q, ny_q;
  logic [31:0] rx_q, ry_q;
  logic [29:0] qx_q, qy_q;
  logic [5:0] cnt_q;
  logic signed [30:0] ux_q, uy_q;
  logic deg_q;

  logic signed [32:0] dx_d, dy_d;
  logic [32:0] m_or;
  logic [61:0] sq_try;
  logic [31:0] tx, ty;
  logic [30:0] rr;

  assign dx_d = $signed({bx_q[31], bx_q}) - $signed({ax_q[31], ax_q});
  assign dy_d = $signed({by_q[31], by_q}) - $signed({ay_q[31], ay_q});
  assign m_or = ex_q | ey_q;
  assign sq_try = res_q + {1'b0, bit_q};
  assign rr = res_q[30:0];
  assign tx = {rx_q[30:0], nx_q[59]};
  assign ty = {ry_q[30:0], ny_q[59]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      deg_q <= 1'b1;
    end else if (cfg_we_i) begin
      state_q <= StLoad;
    end else begin
      unique case (state_q)
        StIdle: ;
        StLoad: begin
          dx_q <= dx_d;
          dy_q <= dy_d;
          ex_q <= dx_d[32] ? 33'(-dx_d) : 33'(dx_d);
          ey_q <= dy_d[32] ? 33'(-dy_d) : 33'(dy_d);
          deg_q <= (dx_d == '0) && (dy_d == '0);
          state_q <= ((dx_d == '0) && (dy_d == '0)) ? StIdle : StNorm;
        end
        StNorm: begin
          if (m_or[32:30] != '0) begin
            ex_q <= ex_q >> 1;
            ey_q <= ey_q >> 1;
          end else if (!m_or[29]) begin
            ex_q <= ex_q << 1;
            ey_q <= ey_q << 1;
          end else begin
            x_q <= 62'(ex_q[29:0] * ex_q[29:0]) + 62'(ey_q[29:0] * ey_q[29:0]);
            res_q <= '0;
            bit_q <= 61'(1) << 60;
            state_q <= StSqrt;
          end
        end
        StSqrt: begin
          if (x_q >= sq_try) begin
            x_q <= x_q - sq_try;
            res_q <= (res_q >> 1) + {1'b0, bit_q};
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) state_q <= StDivLoad;
        end
        StDivLoad: begin
          nx_q <= {ex_q[29:0], 29'd0} + 60'(rr >> 1);
          ny_q <= {ey_q[29:0], 29'd0} + 60'(rr >> 1);
          rx_q <= '0;
          ry_q <= '0;
          qx_q <= '0;
          qy_q <= '0;
          cnt_q <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          // 60 restoring steps
          nx_q <= nx_q << 1;
          ny_q <= ny_q << 1;
          if (tx >= {1'b0, rr}) begin
            rx_q <= tx - {1'b0, rr};
            qx_q <= {qx_q[28:0], 1'b1};
          end else begin
            rx_q <= tx;
            qx_q <= {qx_q[28:0], 1'b0};
          end
          if (ty >= {1'b0, rr}) begin
            ry_q <= ty - {1'b0, rr};
            qy_q <= {qy_q[28:0], 1'b1};
          end else begin
            ry_q <= ty;
            qy_q <= {qy_q[28:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd59) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // direction is loaded once the dividers finish
  logic div_done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_done_q <= 1'b0;
    end else begin
      div_done_q <= (state_q == StDiv) && (cnt_q == 6'd59) && !cfg_we_i;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ux_q <= '0;
      uy_q <= '0;
    end else if (div_done_q) begin
      ux_q <= dx_q[32] ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
      uy_q <= dy_q[32] ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
    end
  end

  logic busy;
  assign busy = (state_q != StIdle) || div_done_q;

  // item pipeline, stalls as a whole when the output register is held
  logic adv;
  logic [4:0] v_q;
  logic out_v_q;
  assign adv = !out_v_q || out_ready_i;
  assign in_ready_o = adv && !busy;

  logic signed [31:0] px1_q, py1_q, px2_q, py2_q, px3_q, py3_q, px4_q, py4_q;
  logic signed [31:0] px5_q, py5_q;
  logic signed [32:0] ddx_q, ddy_q;
  logic signed [27:0] s1_q, s2_q;
  logic signed [63:0] p1_q, p2_q;
  logic signed [65:0] q3_q;
  logic signed [37:0] sd4_q, sd5_q;
  logic signed [68:0] m1_q, m2_q;
  logic [31:0] sd_o_q, fx_o_q, fy_o_q;
  logic deg_o_q;

  logic signed [65:0] q_d;
  logic [65:0] qm;
  logic [36:0] sdm;
  logic [68:0] m1m, m2m;
  logic [39:0] r1m, r2m;
  logic signed [40:0] r1, r2, fx_d, fy_d;

  assign q_d = ($signed(66'(s2_q)) <<< 29) - 66'(p1_q) + 66'(p2_q);
  assign qm = q3_q[65] ? 66'(-q3_q) : 66'(q3_q);
  assign sdm = 37'((qm + (66'd1 << 28)) >> 29);
  assign m1m = m1_q[68] ? 69'(-m1_q) : 69'(m1_q);
  assign m2m = m2_q[68] ? 69'(-m2_q) : 69'(m2_q);
  assign r1m = 40'((m1m + (69'd1 << 28)) >> 29);
  assign r2m = 40'((m2m + (69'd1 << 28)) >> 29);
  assign r1 = m1_q[68] ? -$signed({1'b0, r1m}) : $signed({1'b0, r1m});
  assign r2 = m2_q[68] ? -$signed({1'b0, r2m}) : $signed({1'b0, r2m});
  assign fx_d = 41'(px5_q) + r1;
  assign fy_d = 41'(py5_q) - r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q <= {v_q[3:0], in_valid_i && in_ready_o};
      out_v_q <= v_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px1_q <= pos_x_i;
      py1_q <= pos_y_i;
      ddx_q <= $signed({pos_x_i[31], pos_x_i}) - $signed({ax_q[31], ax_q});
      ddy_q <= $signed({pos_y_i[31], pos_y_i}) - $signed({ay_q[31], ay_q});
      s1_q <= 28'(line_number_i * $signed({1'b0, sp_q})) + 28'(off_q);
      px2_q <= px1_q; py2_q <= py1_q; s2_q <= s1_q;
      p1_q <= ddx_q * uy_q;
      p2_q <= ddy_q * ux_q;
      px3_q <= px2_q; py3_q <= py2_q;
      q3_q <= q_d;
      px4_q <= px3_q; py4_q <= py3_q;
      sd4_q <= q3_q[65] ? -$signed({1'b0, sdm}) : $signed({1'b0, sdm});
      px5_q <= px4_q; py5_q <= py4_q; sd5_q <= sd4_q;
      m1_q <= sd4_q * uy_q;
      m2_q <= sd4_q * ux_q;
      sd_o_q <= deg_q ? '0 : sat_field(64'(sd5_q), COORD_WIDTH);
      fx_o_q <= deg_q ? '0 : sat_field(64'(fx_d), COORD_WIDTH);
      fy_o_q <= deg_q ? '0 : sat_field(64'(fy_d), COORD_WIDTH);
      deg_o_q <= deg_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign signed_distance_o = sd_o_q;
  assign foot_x_o = fx_o_q;
  assign foot_y_o = fy_o_q;
  assign degenerate_o = deg_o_q;

`include "assert_macros.svh"
  `ASSERT_IMPL(a_ready_idle, in_ready_o, !busy, "request taken while direction busy")
  `ASSERT_NEXT(a_cfg_blocks, cfg_we_i, !in_ready_o, "ready after register write")
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `ASSERT_IMPL(a_stall_freeze, !adv, !in_ready_o, "request taken during stall")

endmodule

// ===== test/parallel_line_cross_track_offset_tb.sv =====
// Testbench for parallel_line_cross_track_offset: directed table, then random
// positions over several line settings, checked against an in-bench predictor.
// Depends on plcto_pkg and the parallel_line_cross_track_offset RTL.
`timescale 1ns / 1ps

module parallel_line_cross_track_offset_tb;
  import plcto_pkg::*;

  typedef struct packed {
    logic signed [31:0] sdist;
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
    logic               degen;
  } cross_t;

  typedef struct {
    int          ph;
    logic [31:0] px;
    logic [31:0] py;
    logic [9:0]  k;
    bit          typed;
    cross_t      want;
  } dir_row_t;

  localparam logic [31:0] CMax = 32'h7fffffff;
  localparam logic [31:0] CMin = 32'h80000000;
  localparam int NumDir = 16;
  localparam int NumRand = 550;
  localparam int Limit = 400000;
  localparam logic [CfgIdxW-1:0] RegBad6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBad7 = 3'd7;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [FieldW-1:0]        cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [FieldW-1:0] pos_x_i;
  logic signed [FieldW-1:0] pos_y_i;
  logic signed [LineW-1:0]  line_number_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [FieldW-1:0] signed_distance_o;
  logic signed [FieldW-1:0] foot_x_o;
  logic signed [FieldW-1:0] foot_y_o;
  logic                     degenerate_o;

  parallel_line_cross_track_offset u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .pos_x_i, .pos_y_i, .line_number_i,
    .out_valid_o, .out_ready_i, .signed_distance_o, .foot_x_o, .foot_y_o,
    .degenerate_o
  );

  // line settings as seen by the predictor
  logic signed [63:0] line_ax, line_ay, line_bx, line_by, line_sp, line_off;

  cross_t pending_q[$];
  int     errors;
  int     n_sent;
  int     n_recv;
  int     n_cfg;
  int     n_degen;
  int     cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // divide by 2^29, nearest, ties away from zero
  function automatic logic signed [63:0] round_q29(input logic signed [63:0] v);
    logic [63:0] m;
    m = v;
    if (v[63]) m = 64'd0 - m;
    m = (m + (64'd1 << 28)) >> 29;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return CMax;
    if (v < -64'sd2147483648) return CMin;
    return v[31:0];
  endfunction

  function automatic cross_t cross_track(input logic signed [31:0] px32,
                                         input logic signed [31:0] py32,
                                         input logic signed [9:0] k10);
    logic signed [63:0] px, py, k, dx, dy, ux, uy, c, s, q, sd;
    logic [63:0] ex, ey, m, r, uxm, uym;
    int bl;
    cross_t res;
    px = px32;
    py = py32;
    k = k10;
    dx = line_bx - line_ax;
    dy = line_by - line_ay;
    res = '0;
    if (dx == 0 && dy == 0) begin
      res.degen = 1'b1;
      return res;
    end
    ex = dx[63] ? 64'd0 - dx : dx;
    ey = dy[63] ? 64'd0 - dy : dy;
    m = (ex > ey) ? ex : ey;
    bl = 0;
    while (bl < 64 && (m >> bl) != 0) bl++;
    if (bl > 30) begin
      ex = ex >> (bl - 30);
      ey = ey >> (bl - 30);
    end else if (bl < 30) begin
      ex = ex << (30 - bl);
      ey = ey << (30 - bl);
    end
    r = isqrt(ex * ex + ey * ey);
    if (r == 0) r = 1;
    uxm = ((ex << 29) + (r >> 1)) / r;
    uym = ((ey << 29) + (r >> 1)) / r;
    ux = dx[63] ? -$signed(uxm) : $signed(uxm);
    uy = dy[63] ? -$signed(uym) : $signed(uym);
    c = (px - line_ax) * uy - (py - line_ay) * ux;
    s = k * line_sp + line_off;
    q = (s <<< 29) - c;
    sd = round_q29(q);
    res.sdist = clamp32(sd);
    res.foot_x = clamp32(px + round_q29(sd * uy));
    res.foot_y = clamp32(py - round_q29(sd * ux));
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch %s: got %h want %h at result %0d", what, got, want, n_recv);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      cross_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result", signed_distance_o, 32'h0);
      end else begin
        w = pending_q.pop_front();
        if (signed_distance_o !== w.sdist) report("signed_distance", signed_distance_o, w.sdist);
        if (foot_x_o !== w.foot_x) report("foot_x", foot_x_o, w.foot_x);
        if (foot_y_o !== w.foot_y) report("foot_y", foot_y_o, w.foot_y);
        if (degenerate_o !== w.degen) begin
          report("degenerate", {31'd0, degenerate_o}, {31'd0, w.degen});
        end
      end
      n_recv++;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver: random stalls, calm stretches, one long hold-off
  initial begin
    int  hold;
    bit  calm;
    bit  held;
    hold = 0;
    calm = 0;
    held = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((cycles % 128) == 0) calm = ($urandom_range(0, 3) == 0);
      if (!held && n_sent >= 60) begin
        held = 1;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 20) hold = gap_len();
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      RegAx: line_ax = $signed(data);
      RegAy: line_ay = $signed(data);
      RegBx: line_bx = $signed(data);
      RegBy: line_by = $signed(data);
      RegSpacing: line_sp = {47'd0, data[16:0]};
      RegOffset: line_off = $signed(data[17:0]);
      default: ;
    endcase
  endtask

  task automatic set_line(input logic [31:0] ax, input logic [31:0] ay,
                          input logic [31:0] bx, input logic [31:0] by,
                          input logic [31:0] sp, input logic [31:0] off);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    write_reg(RegAx, ax);
    write_reg(RegAy, ay);
    write_reg(RegBx, bx);
    write_reg(RegBy, by);
    write_reg(RegSpacing, sp);
    write_reg(RegOffset, off);
    write_reg(RegBad6, $urandom);
    write_reg(RegBad7, $urandom);
    cfg_we_i <= 1'b0;
    n_cfg++;
    if (ax == bx && ay == by) n_degen++;
  endtask

  task automatic send_request(input logic [31:0] px, input logic [31:0] py,
                              input logic [9:0] k, input bit typed,
                              input cross_t want);
    cross_t exp_res;
    in_valid_i <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    line_number_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    exp_res = typed ? want : cross_track(px, py, k);
    pending_q = {pending_q, exp_res};
    n_sent++;
  endtask

  task automatic pause(input bit busy);
    int g;
    g = busy ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  dir_row_t dir_tab [NumDir];

  initial begin
    int      cur_ph;
    int      mode;
    bit      busy;
    logic [31:0] ax, ay, bx, by, sp, off, px, py;
    cross_t  none;
    errors = 0;
    n_sent = 0;
    n_recv = 0;
    n_cfg = 0;
    n_degen = 0;
    none = '0;
    line_ax = 0; line_ay = 0; line_bx = 0; line_by = 0; line_sp = 0; line_off = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= RegAx;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    pos_x_i <= '0;
    pos_y_i <= '0;
    line_number_i <= '0;

    // phase 0: reset registers, A equals B
    // phase 1: A=(0,0) B=(1000,0), spacing 100, distance = k*100 + y
    // phase 2: diagonal line, negative offset, predictor only
    dir_tab = '{
      '{0, 32'd0, 32'd0, 10'd0, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{0, CMax, CMin, 10'h1ff, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{0, CMin, CMax, 10'h200, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{1, 32'd0, 32'd0, 10'd0, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b0}},
      '{1, 32'd7, 32'd5, 10'd0, 1'b1, '{32'd5, 32'd7, 32'd0, 1'b0}},
      '{1, 32'd0, 32'd0, 10'd1, 1'b1, '{32'd100, 32'd0, -32'sd100, 1'b0}},
      '{1, -32'sd7, 32'd3, 10'h3ff, 1'b1, '{-32'sd97, -32'sd7, 32'd100, 1'b0}},
      '{1, 32'd0, 32'd0, 10'h200, 1'b1, '{-32'sd51200, 32'd0, 32'd51200, 1'b0}},
      '{1, 32'd0, 32'd0, 10'h1ff, 1'b1, '{32'd51100, 32'd0, -32'sd51100, 1'b0}},
      '{1, CMax, CMax, 10'd0, 1'b1, '{CMax, CMax, 32'd0, 1'b0}},
      '{1, CMin, CMin, 10'h3ff, 1'b1, '{CMin, CMin, 32'd100, 1'b0}},
      '{1, CMax, CMax, 10'h1ff, 1'b1, '{CMax, CMax, -32'sd51100, 1'b0}},
      '{2, 32'd0, 32'd0, 10'd0, 1'b0, none},
      '{2, CMax, CMax, 10'h1ff, 1'b0, none},
      '{2, CMin, CMin, 10'h200, 1'b0, none},
      '{2, 32'd123456, -32'sd654321, 10'h3f9, 1'b0, none}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_ph = 0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].ph != cur_ph) begin
        cur_ph = dir_tab[i].ph;
        if (cur_ph == 1) set_line(0, 0, 32'd1000, 0, 32'd100, 0);
        else set_line(-32'sd3000, 32'd2000, 32'd4000, -32'sd5000, 32'd100000,
                      -32'sd100000);
      end
      send_request(dir_tab[i].px, dir_tab[i].py, dir_tab[i].k, dir_tab[i].typed,
                   dir_tab[i].want);
      pause(1'b0);
    end

    for (int ph = 0; ph < 10; ph++) begin
      mode = (ph < 2) ? ph + 2 : $urandom_range(0, 4);
      sp = (mode == 2) ? 32'h1ffff :
           {15'($urandom_range(0, 32767)), 17'($urandom_range(0, 100000))};
      off = (mode == 2) ? 32'h00020000 :
            ($urandom_range(0, 1) ? $urandom : $unsigned($urandom_range(0, 200000) - 100000));
      case (mode)
        0: begin
          ax = $urandom_range(0, 200000) - 100000;
          ay = $urandom_range(0, 200000) - 100000;
          bx = $urandom_range(0, 200000) - 100000;
          by = $urandom_range(0, 200000) - 100000;
        end
        2: begin
          ax = CMin; ay = CMin; bx = CMax; by = CMax;
        end
        3: begin
          ax = $urandom; ay = $urandom; bx = ax; by = ay;
        end
        default: begin
          ax = $urandom; ay = $urandom; bx = $urandom; by = $urandom;
        end
      endcase
      if (ph == 1) begin
        ax = CMax; ay = 0; bx = CMin; by = 32'd1;
        sp = 0; off = 32'h0001ffff;
      end
      set_line(ax, ay, bx, by, sp, off);
      busy = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < NumRand / 10; n++) begin
        case ($urandom_range(0, 9))
          0, 1: begin px = $urandom; py = $urandom; end
          2: begin
            px = $urandom_range(0, 1) ? CMax : CMin;
            py = $urandom_range(0, 1) ? CMax : CMin;
          end
          default: begin
            px = ax + $urandom_range(0, 400000) - 200000;
            py = ay + $urandom_range(0, 400000) - 200000;
          end
        endcase
        send_request(px, py, 10'($urandom), 1'b0, none);
        pause(busy);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests and %0d results over %0d line settings (%0d degenerate)",
             n_sent, n_recv, n_cfg + 1, n_degen + 1);
    $display("including saturation, out-of-range spacing/offset and long output stalls");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
